@@ sv/bpra_pkg.sv @@
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared constants, types and helpers of the bitmap page run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

  // Store geometry.
  localparam int unsigned NUM_PAGES  = 4096;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned WORD_BITS  = 32;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);
  localparam int unsigned NUM_WORDS  = NUM_PAGES / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(NUM_WORDS);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);

  // Field widths.
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned SIZE_W   = 25;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NEED_W   = SIZE_W - PAGE_SHIFT + 1;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_PAGE_LIMIT = 1'b0;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam cnt_t PAGES_MAX = CNT_W'(NUM_PAGES);

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREE_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_e;

  // Outcome of evaluating one bitmap word during a scan.
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] hit_bit;
    cnt_t             streak;
  } find_res_t;

  // Byte size rounded up to whole pages.
  function automatic logic [NEED_W-1:0] pages_of(input logic [SIZE_W-1:0] bytes);
    logic [SIZE_W:0] sum;
    sum = {1'b0, bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
    return NEED_W'(sum >> PAGE_SHIFT);
  endfunction

endpackage

`default_nettype wire

@@ sv/bpra_if.sv @@
// ----------------------------------------------------------------------------
// bpra_if
// Request and response channels of the bitmap page run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpra_req_if import bpra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] base_address;

  modport source (output valid, opcode, size_bytes, base_address, input ready);
  modport sink   (input valid, opcode, size_bytes, base_address, output ready);
endinterface

interface bpra_rsp_if import bpra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   run_address;
  logic [CNT_W-1:0]    free_pages;

  modport source (output valid, status, run_address, free_pages, input ready);
  modport sink   (input valid, status, run_address, free_pages, output ready);
endinterface

`default_nettype wire

@@ sv/bpra_bitmap_mem.sv @@
// ----------------------------------------------------------------------------
// bpra_bitmap_mem
// Page bitmap store: one 32-bit word per row, registered read.
// Rows never written read as all ones (every page used) through row valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_bitmap_mem import bpra_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   rd_en_i,
  input  wire waddr_t rd_addr_i,
  input  wire logic   wr_en_i,
  input  wire waddr_t wr_addr_i,
  input  wire word_t  wr_data_i,
  output      word_t  rd_data_o
);

  word_t                mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid_q;
  word_t                rd_word_q;
  logic                 rd_valid_q;

  // Array write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
    end
  end

  // Row valid bits, cleared at reset so the bitmap starts all used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '1;

endmodule

`default_nettype wire

@@ sv/bpra_run_finder.sv @@
// ----------------------------------------------------------------------------
// bpra_run_finder
// Evaluates one bitmap word of a first-fit scan: finds the lowest page in the
// word where the free run reaches the requested length, and the run carried
// into the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_run_finder import bpra_pkg::*; (
  input  wire word_t     word_i,
  input  wire waddr_t    word_addr_i,
  input  wire cnt_t      limit_i,
  input  wire cnt_t      streak_i,
  input  wire cnt_t      need_i,
  output      find_res_t res_o
);

  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W:0]       used_pos [WORD_BITS];
  logic [WORD_BITS-1:0] hit_vec;

  // Pages at or above the limit count as used.
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      free_bits[k] = !word_i[k] &&
                     ({1'b0, word_addr_i, BIT_W'(k)} < limit_i);
    end
  end

  // For each bit, one past the highest used bit at or below it (zero if none).
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      used_pos[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (!free_bits[k]) begin
          used_pos[j] = (BIT_W+1)'(k + 1);
        end
      end
    end
  end

  // Run length ending at each bit, compared with the request.
  always_comb begin
    logic [CNT_W:0] total;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (used_pos[j] == '0) begin
        total = {1'b0, streak_i} + (CNT_W+1)'(j + 1);
      end else begin
        total = (CNT_W+1)'(j + 1) - (CNT_W+1)'(used_pos[j]);
      end
      hit_vec[j] = free_bits[j] && (total >= {1'b0, need_i});
    end
  end

  // Lowest hit wins, and the run carried out of the word.
  always_comb begin
    logic [CNT_W:0] carry;
    res_o.hit     = |hit_vec;
    res_o.hit_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        res_o.hit_bit = BIT_W'(j);
      end
    end
    if (used_pos[WORD_BITS-1] == '0) begin
      carry = {1'b0, streak_i} + (CNT_W+1)'(WORD_BITS);
    end else begin
      carry = (CNT_W+1)'(WORD_BITS) - (CNT_W+1)'(used_pos[WORD_BITS-1]);
    end
    res_o.streak = CNT_W'(carry);
  end

endmodule

`default_nettype wire

@@ sv/bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit physical page run allocator over a bitmap of used pages.
//
//   Channel   Dir  Handshake           Word
//   req_i     in   valid/ready         opcode, size_bytes, base_address
//   rsp_o     out  valid/ready         status, run_address, free_pages
//   APB       in   psel/penable/pready page_limit at byte address 0
//
// One request at a time. Allocate: accept, read the first bitmap word, scan
// 32-page bitmap words in order (up to 128 words) through the single memory
// read port, read and write back each word of the run that gets marked, and
// hand over the response. Free: each bitmap word touched is read and written
// back, then the response. Rejected requests go straight to the response.
// Reset marks every page used through row valid bits; no clearing pass.
// A waiting response holds in the output register while the next request is
// taken; the block stalls only when finishing into a still-full output.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_run_allocator import bpra_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  bpra_req_if.sink               req_i,
  bpra_rsp_if.source             rsp_o
);

  state_e state_q, state_d;

  cnt_t              page_limit_q;
  cnt_t              fc_q, fc_d;
  cnt_t              need_q, need_d;
  cnt_t              streak_q, streak_d;
  logic [WADDR_W:0]  rd_w_q, rd_w_d;
  waddr_t            proc_w_q, proc_w_d;
  logic              rd_pend_q, rd_pend_d;
  waddr_t            last_w_q, last_w_d;
  page_t             lo_q, lo_d;
  page_t             hi_q, hi_d;
  waddr_t            mw_q, mw_d;
  logic              set_q, set_d;
  status_e           res_st_q, res_st_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [ADDR_W-1:0]   out_addr_q;
  cnt_t                out_fc_q;

  logic        req_fire;
  logic        out_load;
  cnt_t        limit_eff;
  logic        scan_issue;
  logic        mem_rd_en;
  waddr_t      mem_rd_addr;
  logic        mem_wr_en;
  word_t       mem_wr_data;
  word_t       mem_rd_data;
  find_res_t   find;

  logic [NEED_W-1:0] req_pages;
  page_t             free_first;
  logic [PAGE_W+2:0] free_end;
  logic [CNT_W+1:0]  fc_sum;
  page_t             hit_end;
  page_t             hit_base;
  word_t             mark_mask;
  logic              alloc_reject;
  logic              free_reject;

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_limit_q <= PAGES_MAX;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PAGE_LIMIT)) begin
      page_limit_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PAGE_LIMIT) ? APB_DW'(page_limit_q) : '0;

  assign limit_eff = (page_limit_q > PAGES_MAX) ? PAGES_MAX : page_limit_q;

  // --------------------------------------------------------------------------
  // Request decode.
  // --------------------------------------------------------------------------
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign req_pages  = pages_of(req_i.size_bytes);
  assign free_first = PAGE_W'(req_i.base_address >> PAGE_SHIFT);
  assign free_end   = (PAGE_W+3)'(free_first) + (PAGE_W+3)'(req_pages);
  assign fc_sum     = (CNT_W+2)'(fc_q) + (CNT_W+2)'(req_pages);

  assign alloc_reject = (req_i.size_bytes == '0) ||
                        (req_pages > NEED_W'(fc_q)) ||
                        (limit_eff == '0);
  assign free_reject  = (req_i.base_address == '0) || (req_i.size_bytes == '0);

  // --------------------------------------------------------------------------
  // Bitmap store and word evaluation.
  // --------------------------------------------------------------------------
  assign scan_issue  = (state_q == S_SCAN) && (rd_w_q <= {1'b0, last_w_q});
  assign mem_rd_en   = scan_issue || (state_q == S_MARK_RD);
  assign mem_rd_addr = (state_q == S_SCAN) ? rd_w_q[WADDR_W-1:0] : mw_q;
  assign mem_wr_en   = (state_q == S_MARK_WR);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mark_mask[k] = ({mw_q, BIT_W'(k)} >= lo_q) && ({mw_q, BIT_W'(k)} <= hi_q);
    end
  end

  assign mem_wr_data = set_q ? (mem_rd_data | mark_mask) : (mem_rd_data & ~mark_mask);

  bpra_bitmap_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mw_q),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  bpra_run_finder u_finder (
    .word_i      (mem_rd_data),
    .word_addr_i (proc_w_q),
    .limit_i     (limit_eff),
    .streak_i    (streak_q),
    .need_i      (need_q),
    .res_o       (find)
  );

  assign hit_end  = {proc_w_q, find.hit_bit};
  assign hit_base = hit_end + PAGE_W'(1) - PAGE_W'(need_q);

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.opcode == OP_FREE) begin
            state_d = free_reject ? S_DONE : S_MARK_RD;
          end else begin
            state_d = alloc_reject ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_pend_q) begin
          if (find.hit) begin
            state_d = S_MARK_RD;
          end else if (proc_w_q == last_w_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_MARK_RD: state_d = S_MARK_WR;
      S_MARK_WR: begin
        state_d = (mw_q == hi_q[PAGE_W-1:BIT_W]) ? S_DONE : S_MARK_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath updates.
  // --------------------------------------------------------------------------
  always_comb begin
    fc_d       = fc_q;
    need_d     = need_q;
    streak_d   = streak_q;
    rd_w_d     = rd_w_q;
    proc_w_d   = proc_w_q;
    rd_pend_d  = 1'b0;
    last_w_d   = last_w_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mw_d       = mw_q;
    set_d      = set_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_addr_d = '0;
          if (req_i.opcode == OP_FREE) begin
            if (free_reject) begin
              res_st_d = ST_FREE_IGNORED;
            end else begin
              res_st_d = ST_DONE;
              lo_d     = free_first;
              mw_d     = free_first[PAGE_W-1:BIT_W];
              set_d    = 1'b0;
              if (free_end > (PAGE_W+3)'(NUM_PAGES)) begin
                hi_d = PAGE_W'(NUM_PAGES - 1);
              end else begin
                hi_d = PAGE_W'(free_end - (PAGE_W+3)'(1));
              end
              fc_d = (fc_sum > (CNT_W+2)'(NUM_PAGES)) ? PAGES_MAX : CNT_W'(fc_sum);
            end
          end else begin
            res_st_d = ST_ALLOC_FAIL;
            need_d   = CNT_W'(req_pages);
            streak_d = '0;
            rd_w_d   = '0;
            last_w_d = WADDR_W'((limit_eff - CNT_W'(1)) >> BIT_W);
          end
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          rd_w_d    = rd_w_q + (WADDR_W+1)'(1);
          proc_w_d  = rd_w_q[WADDR_W-1:0];
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          streak_d = find.streak;
          if (find.hit) begin
            res_st_d   = ST_DONE;
            res_addr_d = ADDR_W'({hit_base, PAGE_SHIFT'(0)});
            fc_d       = fc_q - need_q;
            lo_d       = hit_base;
            hi_d       = hit_end;
            mw_d       = hit_base[PAGE_W-1:BIT_W];
            set_d      = 1'b1;
          end
        end
      end
      S_MARK_WR: begin
        mw_d = mw_q + WADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fc_q      <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    streak_q   <= streak_d;
    rd_w_q     <= rd_w_d;
    proc_w_q   <= proc_w_d;
    last_w_q   <= last_w_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mw_q       <= mw_d;
    set_q      <= set_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
  end

  // --------------------------------------------------------------------------
  // Output register: holds one response word until it is taken.
  // --------------------------------------------------------------------------
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
      out_fc_q   <= fc_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.run_address = out_addr_q;
  assign rsp_o.free_pages  = out_fc_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= PAGES_MAX)
    else $error("free count above the number of pages");

  a_scan_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (need_q != '0) && (need_q <= fc_q))
    else $error("scan running with an unsatisfiable request");

  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK_WR) |->
      (mw_q >= lo_q[PAGE_W-1:BIT_W]) && (mw_q <= hi_q[PAGE_W-1:BIT_W]))
    else $error("marking a word outside the run");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("accepted request did not start");

endmodule

`default_nettype wire
